### sv/dqmr_pkg.sv
// Shared types and codes for the deque with middle read.
// Holds the request and response payload structs, opcode and status codes,
// and the control structs passed between the controller, the cells and the top level.
package dqmr_pkg;

   localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [2:0] OP_POP_FRONT  = 3'd2;
   localparam logic [2:0] OP_POP_BACK   = 3'd3;
   localparam logic [2:0] OP_QUERY      = 3'd4;

   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic [2:0]         opcode;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] middle_value;
      logic               is_empty;
      logic [1:0]         status;
   } rsp_type;

   typedef struct packed {
      logic shift_right;
      logic shift_left;
   } cell_cmd_type;

   typedef struct packed {
      logic       strobe;
      logic       is_empty;
      logic [1:0] status;
   } ctrl_status_type;

endpackage

### sv/dqmr_cell.sv
// One storage cell of the deque row.
// Depends on dqmr_pkg for the shift command struct; takes data from either
// neighbor, loads a pushed value, or holds.
module dqmr_cell (
   input  logic                  clock,
   input  dqmr_pkg::cell_cmd_type cmd,
   input  logic                  load,
   input  logic signed [31:0]    load_value,
   input  logic signed [31:0]    left_data,
   input  logic signed [31:0]    right_data,
   output logic signed [31:0]    data
);
   import dqmr_pkg::*;

   logic signed [31:0] data_ff;
   logic signed [31:0] data_in;

   always_comb begin
      priority if (load) begin
         data_in = load_value;
      end else if (cmd.shift_right) begin
         data_in = left_data;
      end else if (cmd.shift_left) begin
         data_in = right_data;
      end else begin
         data_in = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

### sv/dqmr_ctrl.sv
// Controller of the deque: element count, row shift commands and load select.
// Depends on dqmr_pkg for opcodes, status codes and the control structs.
// The middle element always sits in the center cell of the row.
module dqmr_ctrl #(
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic [2:0]               opcode,
   output dqmr_pkg::cell_cmd_type   cmd,
   output logic [DEPTH-1:0]         load_sel,
   output dqmr_pkg::ctrl_status_type ctrl_status
);
   import dqmr_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);
   localparam int PW = $clog2(DEPTH);
   localparam logic [CW:0] CENTER = (CW + 1)'(DEPTH / 2);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   logic [CW-1:0] count_ff, count_in;
   logic [1:0]    status_ff, status_in;
   logic          strobe_ff;

   logic [CW-1:0] half, upper;
   logic [CW:0]   lo, lo_m1, hi_p1, hi, pos;
   logic          load_en;
   logic          odd;

   assign half  = count_ff >> 1;
   assign upper = count_ff - half;
   assign lo    = CENTER - {1'b0, half};
   assign lo_m1 = lo - (CW + 1)'(1);
   assign hi_p1 = CENTER + {1'b0, upper};
   assign hi    = hi_p1 - (CW + 1)'(1);
   assign odd   = count_ff[0];

   always_comb begin
      count_in        = count_ff;
      status_in       = ST_DONE;
      cmd.shift_right = 1'b0;
      cmd.shift_left  = 1'b0;
      load_en         = 1'b0;
      pos             = lo;
      if (accept) begin
         unique case (opcode)
            OP_PUSH_FRONT: begin
               if (count_ff == FULL_COUNT) begin
                  status_in = ST_FULL;
               end else begin
                  count_in = count_ff + CW'(1);
                  load_en  = 1'b1;
                  if (odd) begin
                     pos = lo_m1;
                  end else begin
                     cmd.shift_right = 1'b1;
                     pos             = lo;
                  end
               end
            end
            OP_PUSH_BACK: begin
               if (count_ff == FULL_COUNT) begin
                  status_in = ST_FULL;
               end else begin
                  count_in = count_ff + CW'(1);
                  load_en  = 1'b1;
                  if (odd) begin
                     cmd.shift_left = 1'b1;
                     pos            = hi;
                  end else begin
                     pos = hi_p1;
                  end
               end
            end
            OP_POP_FRONT: begin
               if (count_ff == '0) begin
                  status_in = ST_EMPTY;
               end else begin
                  count_in       = count_ff - CW'(1);
                  cmd.shift_left = odd;
               end
            end
            OP_POP_BACK: begin
               if (count_ff == '0) begin
                  status_in = ST_EMPTY;
               end else begin
                  count_in        = count_ff - CW'(1);
                  cmd.shift_right = !odd;
               end
            end
            default: begin
               status_in = ST_DONE;
            end
         endcase
      end
   end

   for (genvar k = 0; k < DEPTH; k++) begin : g_sel
      assign load_sel[k] = load_en && (pos[PW-1:0] == PW'(k));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         status_ff <= ST_DONE;
         strobe_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         status_ff <= status_in;
         strobe_ff <= accept;
      end
   end

   assign ctrl_status.strobe   = strobe_ff;
   assign ctrl_status.is_empty = (count_ff == '0);
   assign ctrl_status.status   = status_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("element count above depth");

   a_strobe_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> strobe_ff)
      else $error("accepted transaction without response strobe");

   a_full_reject: assert property (@(posedge clock) disable iff (reset)
      accept && count_ff == FULL_COUNT
      && (opcode == OP_PUSH_FRONT || opcode == OP_PUSH_BACK)
      |=> status_ff == ST_FULL && $stable(count_ff))
      else $error("push on full queue not rejected");

   a_single_load: assert property (@(posedge clock) disable iff (reset)
      $onehot0(load_sel))
      else $error("more than one cell loaded");
`endif

endmodule

### sv/deque_with_middle_read.sv
// Top level of the deque with middle read: a row of cells and its controller.
// Depends on dqmr_pkg, dqmr_cell and dqmr_ctrl.
//
// Usage: a transaction is taken at a rising edge where start is high and busy is
// low. busy is always low, so one transaction can be taken in every cycle.
// req_payload carries the opcode (push front, push back, pop front, pop back,
// query) and the value to push.
// Each transaction gives one response on rsp_payload, marked by rsp_strobe for
// exactly one cycle, in the cycle right after the transaction was taken; the
// throughput is one transaction per cycle.
// The response carries the middle element at index count/2 (0 when empty), the
// empty flag and a status: done, push rejected because full, or pop ignored.
// Storage is a row of DEPTH cells that shift toward either neighbor; the middle
// element always sits in the center cell, so no read mux is needed. The element
// count in the controller sets all shift decisions.
// The receiver cannot stall; every response must be taken when strobed.
// A synchronous reset empties the queue; cell contents are left as they are
// and are never read until written.
module deque_with_middle_read #(
   parameter int DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  dqmr_pkg::req_type  req_payload,
   output logic               rsp_strobe,
   output dqmr_pkg::rsp_type  rsp_payload
);
   import dqmr_pkg::*;

   localparam int CENTER = DEPTH / 2;

   logic                  accept;
   cell_cmd_type          cmd;
   logic [DEPTH-1:0]      load_sel;
   ctrl_status_type       ctrl_status;
   logic signed [31:0]    cell_data [DEPTH];

   assign busy   = 1'b0;
   assign accept = start && !busy;

   dqmr_ctrl #(
      .DEPTH(DEPTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .opcode     (req_payload.opcode),
      .cmd        (cmd),
      .load_sel   (load_sel),
      .ctrl_status(ctrl_status)
   );

   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      logic signed [31:0] left_data;
      logic signed [31:0] right_data;

      if (k == 0) begin : g_first
         assign left_data = cell_data[k];
      end else begin : g_inner_l
         assign left_data = cell_data[k-1];
      end

      if (k == DEPTH - 1) begin : g_last
         assign right_data = cell_data[k];
      end else begin : g_inner_r
         assign right_data = cell_data[k+1];
      end

      dqmr_cell u_cell (
         .clock     (clock),
         .cmd       (cmd),
         .load      (load_sel[k]),
         .load_value(req_payload.value),
         .left_data (left_data),
         .right_data(right_data),
         .data      (cell_data[k])
      );
   end

   assign rsp_strobe               = ctrl_status.strobe;
   assign rsp_payload.is_empty     = ctrl_status.is_empty;
   assign rsp_payload.status       = ctrl_status.status;
   assign rsp_payload.middle_value = ctrl_status.is_empty ? 32'sd0 : cell_data[CENTER];

`ifndef ASSERT_OFF
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_payload.is_empty |-> rsp_payload.middle_value == 32'sd0)
      else $error("empty queue reports nonzero middle element");

   a_one_response: assert property (@(posedge clock) disable iff (reset)
      !accept |=> !rsp_strobe)
      else $error("response strobe without a transaction");

   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_payload.status == ST_EMPTY |-> rsp_payload.is_empty)
      else $error("ignored pop on a queue that is not empty");
`endif

endmodule

### tb/testbench.sv
// Self-checking testbench for deque_with_middle_read: random and directed deque
// operations, each response checked against a local ring-buffer model of the deque.
// Depends on dqmr_pkg and the deque_with_middle_read RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import dqmr_pkg::*;

   localparam int DEPTH = 16;
   localparam int STALL_LIMIT = 2000;
   localparam int OP_TARGET = 850;

   typedef struct {
      req_type     op;
      int unsigned gap;
      bit          drain;
   } queued_op_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_payload = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_payload;

   queued_op_type ops_to_send[$];
   rsp_type       answers_due[$];

   logic signed [31:0] ring[DEPTH];
   logic [3:0]         head = '0;
   logic [4:0]         fill = '0;

   int unsigned idle_run = 0;
   int unsigned sent_count = 0;
   int unsigned checked_count = 0;
   int unsigned full_rejects = 0;
   int unsigned empty_pops = 0;
   int unsigned mismatches = 0;
   int unsigned stall_cycles = 0;

   deque_with_middle_read #(
      .DEPTH(DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_payload(req_payload),
      .rsp_strobe (rsp_strobe),
      .rsp_payload(rsp_payload)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic rsp_type deque_apply(input req_type r);
      rsp_type    o;
      logic [3:0] mid_slot;
      o.status = ST_DONE;
      case (r.opcode)
         OP_PUSH_FRONT: begin
            if (fill == DEPTH) begin
               o.status = ST_FULL;
            end else begin
               head = head - 4'd1;
               ring[head] = r.value;
               fill = fill + 5'd1;
            end
         end
         OP_PUSH_BACK: begin
            if (fill == DEPTH) begin
               o.status = ST_FULL;
            end else begin
               ring[head + fill[3:0]] = r.value;
               fill = fill + 5'd1;
            end
         end
         OP_POP_FRONT: begin
            if (fill == 0) begin
               o.status = ST_EMPTY;
            end else begin
               head = head + 4'd1;
               fill = fill - 5'd1;
            end
         end
         OP_POP_BACK: begin
            if (fill == 0) begin
               o.status = ST_EMPTY;
            end else begin
               fill = fill - 5'd1;
            end
         end
         default: begin
         end
      endcase
      mid_slot = head + 4'(fill >> 1);
      o.is_empty = (fill == 0);
      o.middle_value = (fill == 0) ? 32'sd0 : ring[mid_slot];
      return o;
   endfunction

   task automatic add_op(input logic [2:0] opcode, input logic [31:0] value,
                         input int unsigned gap, input bit drain);
      queued_op_type q;
      q.op.opcode = opcode;
      q.op.value = value;
      q.gap = gap;
      q.drain = drain;
      ops_to_send.insert(ops_to_send.size(), q);
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0000_0000;
         3: return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   function automatic int unsigned pick_gap(input bit quiet);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (quiet || roll < 60) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t ns: %s mismatch, got %h, expected %h", $time, what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin : drive
      logic took;
      logic present;
      took = start && !busy;
      if (reset) begin
         start <= 1'b0;
         idle_run = 0;
      end else begin
         if (took) begin
            answers_due.insert(answers_due.size(), deque_apply(req_payload));
            sent_count++;
         end
         present = start && !took;
         if (!present && ops_to_send.size() != 0) begin
            if (idle_run >= ops_to_send[0].gap &&
                !(ops_to_send[0].drain && answers_due.size() != 0)) begin
               req_payload <= ops_to_send[0].op;
               ops_to_send.delete(0);
               idle_run = 0;
               present = 1'b1;
            end else begin
               idle_run++;
            end
         end
         start <= present;
      end
   end

   always @(posedge clock) begin : check
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (answers_due.size() == 0) begin
            report_mismatch("unexpected response", rsp_payload.middle_value, 32'h0);
         end else begin
            want = answers_due[0];
            answers_due.delete(0);
            checked_count++;
            if (want.status == ST_FULL) full_rejects++;
            if (want.status == ST_EMPTY) empty_pops++;
            if (rsp_payload.middle_value !== want.middle_value)
               report_mismatch("middle_value", rsp_payload.middle_value, want.middle_value);
            if (rsp_payload.is_empty !== want.is_empty)
               report_mismatch("is_empty", 32'(rsp_payload.is_empty), 32'(want.is_empty));
            if (rsp_payload.status !== want.status)
               report_mismatch("status", 32'(rsp_payload.status), 32'(want.status));
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (!reset) begin
         if ((start && !busy) || rsp_strobe) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
         end
         if (stall_cycles == STALL_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("** deque_with_middle_read: FAILED **");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int unsigned seg_len;
      int unsigned mood;
      int unsigned push_bias;
      int unsigned roll;
      bit          quiet;
      logic [2:0]  opcode;

      // Empty-queue corner cases, extreme values and the unused opcodes.
      add_op(OP_QUERY, 32'h1234_5678, 0, 1'b0);
      add_op(OP_POP_FRONT, 32'h0, 0, 1'b0);
      add_op(OP_POP_BACK, 32'hffff_ffff, 1, 1'b0);
      add_op(OP_PUSH_FRONT, 32'h8000_0000, 0, 1'b0);
      add_op(OP_PUSH_BACK, 32'h7fff_ffff, 0, 1'b0);
      add_op(OP_PUSH_FRONT, 32'hffff_ffff, 2, 1'b0);
      add_op(OP_PUSH_BACK, 32'h0000_0000, 0, 1'b0);
      add_op(OP_QUERY + 3'd1, 32'h5555_5555, 0, 1'b0);
      add_op(OP_QUERY + 3'd2, 32'haaaa_aaaa, 0, 1'b0);
      add_op(OP_QUERY + 3'd3, 32'hffff_ffff, 0, 1'b0);
      add_op(OP_POP_FRONT, 32'h0, 0, 1'b0);
      add_op(OP_POP_BACK, 32'h0, 0, 1'b0);
      add_op(OP_POP_FRONT, 32'h0, 0, 1'b0);
      add_op(OP_POP_BACK, 32'h0, 0, 1'b0);
      add_op(OP_POP_FRONT, 32'h0, 0, 1'b1);
      add_op(OP_POP_BACK, 32'h0, 0, 1'b0);
      add_op(OP_QUERY, 32'h0, 0, 1'b0);

      while (ops_to_send.size() < OP_TARGET) begin
         seg_len = $urandom_range(12, 40);
         mood = $urandom_range(0, 2);
         quiet = ($urandom_range(0, 3) == 0);
         push_bias = (mood == 0) ? 85 : (mood == 1) ? 15 : 50;
         for (int unsigned i = 0; i < seg_len; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 6) begin
               opcode = OP_QUERY + 3'($urandom_range(0, 3));
            end else if ($urandom_range(0, 99) < push_bias) begin
               opcode = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
            end else begin
               opcode = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
            end
            add_op(opcode, pick_value(), pick_gap(quiet), $urandom_range(0, 79) == 0);
         end
      end

      do @(negedge clock);
      while (ops_to_send.size() != 0 || start || answers_due.size() != 0);
      repeat (4) @(posedge clock);

      $display("Sent %0d transactions and checked %0d responses.", sent_count, checked_count);
      $display("Pushes refused on a full queue: %0d, pops on an empty queue: %0d.",
               full_rejects, empty_pops);
      if (mismatches == 0) begin
         $display("** deque_with_middle_read: PASSED **");
      end else begin
         $display("** deque_with_middle_read: FAILED **");
      end
      $finish;
   end

endmodule
